// File: src/gda_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the Gregorian date block.
package gda_pkg;

    // Datapath, constant operand and quotient widths
    localparam int unsigned DW = 36;
    localparam int unsigned KW = 19;
    localparam int unsigned QW = 12;

    // Divider widths: divisor, dividend magnitude, reciprocal and its scale
    localparam int unsigned DCW    = 21;
    localparam int unsigned RCP_AW = 30;
    localparam int unsigned RCP_MW = 27;
    localparam int unsigned RCP_SH = 30;

    // Field widths
    localparam int unsigned CMD_W = 2;
    localparam int unsigned MON_W = 4;
    localparam int unsigned DAY_W = 5;
    localparam int unsigned YR_W  = 14;
    localparam int unsigned OFF_W = 23;
    localparam int unsigned JDN_W = 23;
    localparam int unsigned DOY_W = 9;
    localparam int unsigned WD_W  = 3;
    localparam int unsigned ST_W  = 2;

    // Default date and default year limit
    localparam int unsigned MAX_YEAR_DEF = 9999;
    localparam logic [MON_W-1:0] DEF_MONTH = MON_W'(5);
    localparam logic [DAY_W-1:0] DEF_DAY   = DAY_W'(11);
    localparam int unsigned      DEF_YEAR  = 1959;

    typedef logic signed [DW-1:0] t_sdw;
    typedef logic signed [KW-1:0] t_sk;
    typedef logic signed [QW:0]   t_sq;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_SHIFT = 2'd1,
        CMD_CMP   = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_REJECT = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE  = 2'd2;

    // Divisor selection for the shared divider
    typedef enum logic [2:0] {
        DS_100,
        DS_146097,
        DS_1461001,
        DS_2447,
        DS_80,
        DS_11
    } t_dsel;

    function automatic logic [DCW-1:0] div_const(input t_dsel sel);
        logic [DCW-1:0] v;
        case (sel)
            DS_100:     v = DCW'(100);
            DS_146097:  v = DCW'(146097);
            DS_1461001: v = DCW'(1461001);
            DS_2447:    v = DCW'(2447);
            DS_80:      v = DCW'(80);
            DS_11:      v = DCW'(11);
            default:    v = DCW'(1);
        endcase
        return v;
    endfunction

    // floor(2^30 / divisor); the estimate it gives is at most one below the quotient
    function automatic logic [RCP_MW-1:0] recip_const(input t_dsel sel);
        logic [RCP_MW-1:0] v;
        case (sel)
            DS_100:     v = RCP_MW'(10737418);
            DS_146097:  v = RCP_MW'(7349);
            DS_1461001: v = RCP_MW'(734);
            DS_2447:    v = RCP_MW'(438799);
            DS_80:      v = RCP_MW'(13421772);
            DS_11:      v = RCP_MW'(97612893);
            default:    v = RCP_MW'(1073741823);
        endcase
        return v;
    endfunction

    // 367 * (m - 2 - 12a) / 12 for every month code
    function automatic logic [8:0] month_term(input logic [MON_W-1:0] m);
        logic [8:0] v;
        case (m)
            4'd0:    v = 9'd305;
            4'd1:    v = 9'd336;
            4'd2:    v = 9'd367;
            4'd3:    v = 9'd30;
            4'd4:    v = 9'd61;
            4'd5:    v = 9'd91;
            4'd6:    v = 9'd122;
            4'd7:    v = 9'd152;
            4'd8:    v = 9'd183;
            4'd9:    v = 9'd214;
            4'd10:   v = 9'd244;
            4'd11:   v = 9'd275;
            4'd12:   v = 9'd305;
            4'd13:   v = 9'd336;
            4'd14:   v = 9'd367;
            default: v = 9'd397;
        endcase
        return v;
    endfunction

    // Divide by four, truncating towards zero
    function automatic t_sdw sdiv4(input t_sdw v);
        t_sdw r;
        if (v < 0) begin
            r = -((-v) >>> 2);
        end else begin
            r = v >>> 2;
        end
        return r;
    endfunction

    // Remainder modulo 7 of a non-negative value: octal digits sum, since 8 = 1 mod 7
    function automatic logic [WD_W-1:0] mod7(input logic [DW-1:0] v);
        logic [6:0] s;
        logic [3:0] t;
        s = '0;
        for (int i = 0; i < DW / 3; i++) begin
            s = s + 7'(v[3*i +: 3]);
        end
        t = 4'(s[2:0]) + 4'(s[5:3]) + 4'(s[6]);
        if (t >= 4'd7) begin
            t = t - 4'd7;
        end
        if (t >= 4'd7) begin
            t = t - 4'd7;
        end
        return t[2:0];
    endfunction

endpackage

// File: src/gda_if.sv
`timescale 1ns / 1ps
// Command and result channel interfaces.
interface gda_in_if import gda_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic [MON_W-1:0]        in_month;
    logic [DAY_W-1:0]        in_day;
    logic [YR_W-1:0]         in_year;
    logic signed [OFF_W-1:0] day_offset;

    modport source (output valid, command, in_month, in_day, in_year, day_offset,
                    input ready);
    modport sink   (input valid, command, in_month, in_day, in_year, day_offset,
                    output ready);
endinterface

interface gda_out_if import gda_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [MON_W-1:0]        out_month;
    logic [DAY_W-1:0]        out_day;
    logic [YR_W-1:0]         out_year;
    logic [JDN_W-1:0]        day_number;
    logic [DOY_W-1:0]        day_of_year;
    logic [WD_W-1:0]         weekday;
    logic signed [OFF_W-1:0] days_between;
    logic [ST_W-1:0]         status;

    modport source (output valid, out_month, out_day, out_year, day_number, day_of_year,
                    weekday, days_between, status, input ready);
    modport sink   (input valid, out_month, out_day, out_year, day_number, day_of_year,
                    weekday, days_between, status, output ready);
endinterface

// File: src/gda_mul.sv
`timescale 1ns / 1ps
// Shared multiplier by a small constant, with a registered product.
module gda_mul import gda_pkg::*; (
    input  logic i_clk,
    input  t_sdw i_a,
    input  t_sk  i_k,
    output t_sdw o_p
);
    t_sdw r_p;

    // Register the truncated product
    always_ff @(posedge i_clk) begin
        r_p <= t_sdw'(i_a * i_k);
    end

    assign o_p = r_p;
endmodule

// File: src/gda_div.sv
`timescale 1ns / 1ps
// Shared divider by a selected constant: reciprocal multiply and one correction step.
module gda_div import gda_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_sdw  i_x,
    input  t_dsel i_sel,
    output logic  o_done,
    output t_sq   o_q
);
    logic [RCP_AW-1:0]        r_ax;
    logic                     r_neg;
    logic [RCP_MW-1:0]        r_m;
    logic [DCW-1:0]           r_c;
    logic [RCP_AW+RCP_MW-1:0] r_p;
    logic [QW-1:0]            r_q0;
    logic [QW+DCW-1:0]        r_r;
    logic [3:0]               r_v;
    logic                     r_done;
    t_sq                      r_q;

    logic [QW+DCW-1:0] n_qc;
    logic [QW+DCW-1:0] n_r;
    logic [QW-1:0]     n_q;

    // Remainder of the estimate, then step the estimate up when it is one short
    always_comb begin
        n_qc = (QW+DCW)'(r_q0) * (QW+DCW)'(r_c);
        n_r  = (QW+DCW)'(r_ax) - n_qc;
        n_q  = r_q0 + QW'(r_r >= (QW+DCW)'(r_c));
    end

    // Advance the stage flags and flag the quotient
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r_done <= 1'b0;
        end else begin
            r_v    <= {r_v[2:0], i_start};
            r_done <= r_v[3];
        end
    end

    // Capture the operand, multiply by the reciprocal, correct and sign the quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ax  <= (i_x < 0) ? RCP_AW'(-i_x) : RCP_AW'(i_x);
            r_neg <= (i_x < 0);
            r_m   <= recip_const(i_sel);
            r_c   <= div_const(i_sel);
        end
        r_p  <= r_ax * r_m;
        r_q0 <= r_p[RCP_SH+QW-1:RCP_SH];
        r_r  <= n_r;
        if (r_v[3]) begin
            r_q <= r_neg ? -t_sq'({1'b0, n_q}) : t_sq'({1'b0, n_q});
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule

// File: src/gregorian_date_arithmetic.sv
`timescale 1ns / 1ps
// Gregorian date unit: load, shift and compare through Julian day numbers.
//
//  Channel  Dir  Transaction
//  i_in     in   command, in_month, in_day, in_year, day_offset
//  o_out    out  out_month, out_day, out_year, day_number, day_of_year,
//                weekday, days_between, status
//
// One transaction at a time. The sequencer steps one shared multiplier and one
// shared constant divider (reciprocal multiply plus a correction step). Reset
// restores May 11 1959. A result waiting on o_out stalls the block only when
// the next result is ready to leave.
module gregorian_date_arithmetic import gda_pkg::*; #(
    parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    gda_in_if.sink    i_in,
    gda_out_if.source o_out
);
    localparam int unsigned YLW = $clog2(MAX_YEAR + 1);
    localparam int unsigned YW  = (YLW > YR_W) ? YLW : YR_W;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_FIN,
        S_J_MUL, S_J_ADD, S_J_DIV, S_J_MUL3, S_J_SUB,
        S_SH, S_F_N, S_F_MULN, S_F_L1, S_F_MUL4K, S_F_DIVI_ST, S_F_DIVI,
        S_F_MULI, S_F_L2, S_F_MUL80, S_F_DIVJ_ST, S_F_DIVJ, S_F_MULJ,
        S_F_DIV80_ST, S_F_DIV80, S_F_DIV11_ST, S_F_DIV11, S_F_MUL100, S_F_YEAR,
        S_C_SAVE, S_FN1, S_FN2, S_DONE
    } t_state;

    t_state r_state;
    t_state r_ret;

    // Captured transaction
    t_cmd                    r_cmd;
    logic [MON_W-1:0]        r_im;
    logic [DAY_W-1:0]        r_id;
    logic [YR_W-1:0]         r_iy;
    logic signed [OFF_W-1:0] r_off;

    // Stored date
    logic [MON_W-1:0] r_mon;
    logic [DAY_W-1:0] r_day;
    logic [YW-1:0]    r_yr;

    // Day number operands and working registers
    logic [MON_W-1:0] r_jm;
    logic [DAY_W-1:0] r_jd;
    logic [YW-1:0]    r_jy;
    t_sdw             r_acc;
    t_sdw             r_jg;
    t_sdw             r_jc;
    t_sdw             r_l;
    t_sq              r_n;
    t_sq              r_i;
    t_sq              r_j;
    t_sq              r_l2;
    logic [DAY_W-1:0] r_k;
    logic [ST_W-1:0]  r_st;
    logic signed [OFF_W-1:0] r_btw;
    logic [DOY_W-1:0] r_doy;

    // Output register
    logic                    r_ovalid;
    logic [MON_W-1:0]        r_omon;
    logic [DAY_W-1:0]        r_oday;
    logic [YR_W-1:0]         r_oyr;
    logic [JDN_W-1:0]        r_ojdn;
    logic [DOY_W-1:0]        r_odoy;
    logic [WD_W-1:0]         r_owd;
    logic signed [OFF_W-1:0] r_obtw;
    logic [ST_W-1:0]         r_ost;

    // Shared units
    t_sdw  w_ma;
    t_sk   w_mk;
    t_sdw  w_p;
    logic  w_dstart;
    t_sdw  w_dx;
    t_dsel w_dsel;
    logic  w_ddone;
    t_sq   w_q;

    // Signed views
    t_sdw s_jy, s_jd, s_ja, s_off, s_q, s_lsh, s_ny, s_nm;
    logic w_ok, w_accept, w_oload;

    gda_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_k   (w_mk),
        .o_p   (w_p)
    );

    gda_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_x     (w_dx),
        .i_sel   (w_dsel),
        .o_done  (w_ddone),
        .o_q     (w_q)
    );

    // Widen operands, work out the shifted day number and the date check
    always_comb begin
        s_jy  = t_sdw'(r_jy);
        s_jd  = t_sdw'(r_jd);
        s_ja  = (r_jm <= MON_W'(2)) ? t_sdw'(1) : t_sdw'(0);
        s_off = t_sdw'(r_off);
        s_q   = t_sdw'(w_q);
        s_lsh = r_acc + s_off + t_sdw'(68569);
        s_ny  = w_p + t_sdw'(r_i) + t_sdw'(r_l2);
        s_nm  = t_sdw'(r_j) + t_sdw'(2) - t_sdw'(12) * t_sdw'(r_l2);
        w_ok  = (r_im >= MON_W'(1)) && (r_im <= MON_W'(12))
             && (r_id >= DAY_W'(1))
             && (r_iy >= YR_W'(1)) && (32'(r_iy) <= MAX_YEAR)
             && !((r_im == MON_W'(2)) && (r_id > DAY_W'(29)))
             && !(((r_im == MON_W'(4)) || (r_im == MON_W'(6)) || (r_im == MON_W'(9))
                   || (r_im == MON_W'(11))) && (r_id > DAY_W'(30)));
    end

    // Steer the shared multiplier and divider from the sequencer state
    always_comb begin
        w_ma     = '0;
        w_mk     = '0;
        w_dstart = 1'b0;
        w_dx     = '0;
        w_dsel   = DS_100;
        case (r_state)
            S_J_MUL: begin
                w_ma = s_jy + t_sdw'(4800) - s_ja;
                w_mk = t_sk'(1461);
            end
            S_J_ADD: begin
                w_dstart = 1'b1;
                w_dx     = s_jy + t_sdw'(4900) - s_ja;
                w_dsel   = DS_100;
            end
            S_J_MUL3: begin
                w_ma = s_q;
                w_mk = t_sk'(3);
            end
            S_SH: begin
                w_dstart = 1'b1;
                w_dx     = s_lsh <<< 2;
                w_dsel   = DS_146097;
            end
            S_F_MULN: begin
                w_ma = s_q;
                w_mk = t_sk'(146097);
            end
            S_F_MUL4K: begin
                w_ma = r_l + t_sdw'(1);
                w_mk = t_sk'(4000);
            end
            S_F_DIVI_ST: begin
                w_dstart = 1'b1;
                w_dx     = w_p;
                w_dsel   = DS_1461001;
            end
            S_F_MULI: begin
                w_ma = s_q;
                w_mk = t_sk'(1461);
            end
            S_F_MUL80: begin
                w_ma = r_l;
                w_mk = t_sk'(80);
            end
            S_F_DIVJ_ST: begin
                w_dstart = 1'b1;
                w_dx     = w_p;
                w_dsel   = DS_2447;
            end
            S_F_MULJ: begin
                w_ma = s_q;
                w_mk = t_sk'(2447);
            end
            S_F_DIV80_ST: begin
                w_dstart = 1'b1;
                w_dx     = w_p;
                w_dsel   = DS_80;
            end
            S_F_DIV11_ST: begin
                w_dstart = 1'b1;
                w_dx     = t_sdw'(r_j);
                w_dsel   = DS_11;
            end
            S_F_MUL100: begin
                w_ma = t_sdw'(r_n) - t_sdw'(49);
                w_mk = t_sk'(100);
            end
            default: begin
                w_ma = '0;
            end
        endcase
    end

    assign w_accept = i_in.valid && (r_state == S_IDLE);
    assign w_oload  = (r_state == S_DONE) && (!r_ovalid || o_out.ready);

    // Sequencer: hold state, stored date and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_mon    <= DEF_MONTH;
            r_day    <= DEF_DAY;
            r_yr     <= YW'(DEF_YEAR);
            r_ovalid <= 1'b0;
        end else begin
            if (o_out.ready && r_ovalid && !w_oload) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd <= t_cmd'(i_in.command);
                        r_im  <= i_in.in_month;
                        r_id  <= i_in.in_day;
                        r_iy  <= i_in.in_year;
                        r_off <= i_in.day_offset;
                        r_st  <= ST_OK;
                        case (t_cmd'(i_in.command))
                            CMD_LOAD: begin
                                r_state <= S_LOAD;
                            end
                            CMD_SHIFT: begin
                                r_jm    <= r_mon;
                                r_jd    <= r_day;
                                r_jy    <= r_yr;
                                r_ret   <= S_SH;
                                r_state <= S_J_MUL;
                            end
                            CMD_CMP: begin
                                r_jm    <= i_in.in_month;
                                r_jd    <= i_in.in_day;
                                r_jy    <= YW'(i_in.in_year);
                                r_ret   <= S_C_SAVE;
                                r_state <= S_J_MUL;
                            end
                            default: begin
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_LOAD: begin
                    if (w_ok) begin
                        r_mon <= r_im;
                        r_day <= r_id;
                        r_yr  <= YW'(r_iy);
                    end else begin
                        r_mon <= DEF_MONTH;
                        r_day <= DEF_DAY;
                        r_yr  <= YW'(DEF_YEAR);
                        r_st  <= ST_REJECT;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_jm    <= r_mon;
                    r_jd    <= r_day;
                    r_jy    <= r_yr;
                    r_ret   <= S_FN1;
                    r_state <= S_J_MUL;
                end
                // Day number of (r_jm, r_jd, r_jy) into r_acc
                S_J_MUL: begin
                    r_state <= S_J_ADD;
                end
                S_J_ADD: begin
                    r_acc   <= (w_p >>> 2) + s_jd - t_sdw'(32075)
                             + t_sdw'(month_term(r_jm));
                    r_state <= S_J_DIV;
                end
                S_J_DIV: begin
                    if (w_ddone) begin
                        r_state <= S_J_MUL3;
                    end
                end
                S_J_MUL3: begin
                    r_state <= S_J_SUB;
                end
                S_J_SUB: begin
                    r_acc   <= r_acc - (w_p >>> 2);
                    r_state <= r_ret;
                end
                // Day number back to a date
                S_SH: begin
                    r_l     <= s_lsh;
                    r_state <= S_F_N;
                end
                S_F_N: begin
                    if (w_ddone) begin
                        r_state <= S_F_MULN;
                    end
                end
                S_F_MULN: begin
                    r_n     <= w_q;
                    r_state <= S_F_L1;
                end
                S_F_L1: begin
                    r_l     <= r_l - sdiv4(w_p + t_sdw'(3));
                    r_state <= S_F_MUL4K;
                end
                S_F_MUL4K: begin
                    r_state <= S_F_DIVI_ST;
                end
                S_F_DIVI_ST: begin
                    r_state <= S_F_DIVI;
                end
                S_F_DIVI: begin
                    if (w_ddone) begin
                        r_state <= S_F_MULI;
                    end
                end
                S_F_MULI: begin
                    r_i     <= w_q;
                    r_state <= S_F_L2;
                end
                S_F_L2: begin
                    r_l     <= r_l - sdiv4(w_p) + t_sdw'(31);
                    r_state <= S_F_MUL80;
                end
                S_F_MUL80: begin
                    r_state <= S_F_DIVJ_ST;
                end
                S_F_DIVJ_ST: begin
                    r_state <= S_F_DIVJ;
                end
                S_F_DIVJ: begin
                    if (w_ddone) begin
                        r_state <= S_F_MULJ;
                    end
                end
                S_F_MULJ: begin
                    r_j     <= w_q;
                    r_state <= S_F_DIV80_ST;
                end
                S_F_DIV80_ST: begin
                    r_state <= S_F_DIV80;
                end
                S_F_DIV80: begin
                    if (w_ddone) begin
                        r_k     <= DAY_W'(r_l - s_q);
                        r_state <= S_F_DIV11_ST;
                    end
                end
                S_F_DIV11_ST: begin
                    r_state <= S_F_DIV11;
                end
                S_F_DIV11: begin
                    if (w_ddone) begin
                        r_state <= S_F_MUL100;
                    end
                end
                S_F_MUL100: begin
                    r_l2    <= w_q;
                    r_state <= S_F_YEAR;
                end
                S_F_YEAR: begin
                    if ((s_ny >= t_sdw'(1)) && (s_ny <= t_sdw'(MAX_YEAR))) begin
                        r_mon <= MON_W'(s_nm);
                        r_day <= r_k;
                        r_yr  <= YW'(s_ny);
                    end else begin
                        r_st  <= ST_RANGE;
                    end
                    r_state <= S_FIN;
                end
                S_C_SAVE: begin
                    r_jg    <= r_acc;
                    r_state <= S_FIN;
                end
                // Day number of the stored date, then of the day before January 1
                S_FN1: begin
                    r_jc    <= r_acc;
                    r_btw   <= (r_cmd == CMD_CMP) ? OFF_W'(r_jg - r_acc) : '0;
                    r_jm    <= MON_W'(1);
                    r_jd    <= '0;
                    r_jy    <= r_yr;
                    r_ret   <= S_FN2;
                    r_state <= S_J_MUL;
                end
                S_FN2: begin
                    r_doy   <= DOY_W'(r_jc - r_acc);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_oload) begin
                        r_ovalid <= 1'b1;
                        r_omon   <= r_mon;
                        r_oday   <= r_day;
                        r_oyr    <= YR_W'(r_yr);
                        r_ojdn   <= JDN_W'(r_jc);
                        r_odoy   <= r_doy;
                        r_owd    <= mod7(r_jc);
                        r_obtw   <= r_btw;
                        r_ost    <= r_st;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ovalid;
    assign o_out.out_month    = r_omon;
    assign o_out.out_day      = r_oday;
    assign o_out.out_year     = r_oyr;
    assign o_out.day_number   = r_ojdn;
    assign o_out.day_of_year  = r_odoy;
    assign o_out.weekday      = r_owd;
    assign o_out.days_between = r_obtw;
    assign o_out.status       = r_ost;
endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the Gregorian date unit: directed cases, random traffic and stalls.
module tb;
    import gda_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [MON_W-1:0]        month;
        logic [DAY_W-1:0]        day;
        logic [YR_W-1:0]         year;
        logic [JDN_W-1:0]        jdn;
        logic [DOY_W-1:0]        doy;
        logic [WD_W-1:0]         wday;
        logic signed [OFF_W-1:0] between;
        logic [ST_W-1:0]         status;
    } t_date_res;

    logic i_clk;
    logic i_rst_n;

    gda_in_if  cmd_ch ();
    gda_out_if res_ch ();

    gregorian_date_arithmetic i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch.sink),
        .o_out   (res_ch.source)
    );

    // Model state and pending results
    int          mdl_month, mdl_day, mdl_year;
    t_date_res   pending_dates[$];
    int          fail_count;
    int          idle_cycles;
    bit          src_no_idle;
    bit          snk_no_idle;
    bit          snk_hold;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Civil date to Julian day number, truncating division
    function automatic longint civil_to_jdn(longint m, longint d, longint y);
        longint a;
        a = (m - 14) / 12;
        return d - 32075 + 1461 * (y + 4800 + a) / 4 + 367 * (m - 2 - a * 12) / 12
               - 3 * ((y + 4900 + a) / 100) / 4;
    endfunction

    function automatic void jdn_to_civil(longint jd, output longint m, output longint d,
                                         output longint y);
        longint l, n, i, j, k;
        l = jd + 68569;
        n = 4 * l / 146097;
        l = l - (146097 * n + 3) / 4;
        i = 4000 * (l + 1) / 1461001;
        l = l - 1461 * i / 4 + 31;
        j = 80 * l / 2447;
        k = l - 2447 * j / 80;
        l = j / 11;
        j = j + 2 - 12 * l;
        y = 100 * (n - 49) + i + l;
        m = j;
        d = k;
    endfunction

    function automatic bit load_valid(int m, int d, int y);
        if (m < 1 || m > 12 || d < 1 || d > 31 || y < 1 || y > MAX_YEAR_DEF) return 0;
        if (m == 2 && d > 29) return 0;
        if ((m == 4 || m == 6 || m == 9 || m == 11) && d > 30) return 0;
        return 1;
    endfunction

    // Advance the model by one command and queue the expected result
    function automatic void predict_date(t_cmd cmd, int m, int d, int y, int off);
        t_date_res r;
        longint    jd, nm, nd, ny, between;
        int        st;
        between = 0;
        st = int'(ST_OK);
        case (cmd)
            CMD_LOAD: begin
                if (load_valid(m, d, y)) begin
                    mdl_month = m; mdl_day = d; mdl_year = y;
                end else begin
                    mdl_month = int'(DEF_MONTH); mdl_day = int'(DEF_DAY);
                    mdl_year = int'(DEF_YEAR);
                    st = int'(ST_REJECT);
                end
            end
            CMD_SHIFT: begin
                jd = civil_to_jdn(mdl_month, mdl_day, mdl_year) + off;
                jdn_to_civil(jd, nm, nd, ny);
                if (ny < 1 || ny > MAX_YEAR_DEF) begin
                    st = int'(ST_RANGE);
                end else begin
                    mdl_month = int'(nm); mdl_day = int'(nd); mdl_year = int'(ny);
                end
            end
            CMD_CMP: between = civil_to_jdn(m, d, y) - civil_to_jdn(mdl_month, mdl_day, mdl_year);
            default: ;
        endcase
        jd = civil_to_jdn(mdl_month, mdl_day, mdl_year);
        r.month   = MON_W'(mdl_month);
        r.day     = DAY_W'(mdl_day);
        r.year    = YR_W'(mdl_year);
        r.jdn     = JDN_W'(jd);
        r.doy     = DOY_W'(jd - civil_to_jdn(1, 0, mdl_year));
        r.wday    = WD_W'(((jd % 7) + 7) % 7);
        r.between = OFF_W'(between);
        r.status  = ST_W'(st);
        pending_dates.push_back(r);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Offer one transaction and wait for acceptance; drop valid only while idling
    task automatic send_command(t_cmd cmd, int m, int d, int y, int off);
        while (!src_no_idle && $urandom_range(99) < 35) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.command    <= cmd;
        cmd_ch.in_month   <= MON_W'(m);
        cmd_ch.in_day     <= DAY_W'(d);
        cmd_ch.in_year    <= YR_W'(y);
        cmd_ch.day_offset <= OFF_W'(off);
        do @(posedge i_clk); while (!cmd_ch.ready);
        predict_date(cmd, m, d, y, off);
    endtask

    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
    endtask

    // Drive sink ready
    always @(posedge i_clk) begin
        if (!i_rst_n || snk_hold) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= snk_no_idle || ($urandom_range(99) >= 35);
        end
    end

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin
        t_date_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_dates.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = pending_dates.pop_front();
                if (res_ch.out_month !== want.month)
                    report_mismatch("month", res_ch.out_month, want.month);
                if (res_ch.out_day !== want.day) report_mismatch("day", res_ch.out_day, want.day);
                if (res_ch.out_year !== want.year)
                    report_mismatch("year", res_ch.out_year, want.year);
                if (res_ch.day_number !== want.jdn)
                    report_mismatch("day_number", res_ch.day_number, want.jdn);
                if (res_ch.day_of_year !== want.doy)
                    report_mismatch("day_of_year", res_ch.day_of_year, want.doy);
                if (res_ch.weekday !== want.wday)
                    report_mismatch("weekday", res_ch.weekday, want.wday);
                if (res_ch.days_between !== want.between)
                    report_mismatch("days_between", res_ch.days_between, want.between);
                if (res_ch.status !== want.status)
                    report_mismatch("status", res_ch.status, want.status);
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout");
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_directed();
        send_command(CMD_LOAD, 0, 0, 0, 0);
        send_command(CMD_LOAD, 15, 31, 16383, 0);
        send_command(CMD_LOAD, 2, 30, 2000, 0);
        send_command(CMD_LOAD, 4, 31, 2000, 0);
        send_command(CMD_LOAD, 1, 1, 10000, 0);
        send_command(CMD_LOAD, 2, 29, 2001, 0);
        send_command(CMD_LOAD, 1, 1, 1, 0);
        send_command(CMD_SHIFT, 0, 0, 0, -1);
        send_command(CMD_SHIFT, 0, 0, 0, 4194303);
        send_command(CMD_LOAD, 12, 31, 9999, 0);
        send_command(CMD_SHIFT, 0, 0, 0, 1);
        send_command(CMD_SHIFT, 0, 0, 0, -4194304);
        send_command(CMD_SHIFT, 0, 0, 0, -3652058);
        send_command(CMD_CMP, 0, 0, 0, 0);
        send_command(CMD_CMP, 15, 31, 16383, -1);
        send_command(CMD_CMP, 5, 11, 1959, 0);
        send_command(CMD_NONE, 15, 31, 16383, -1);
        send_command(CMD_LOAD, 12, 31, 2000, 0);
        send_command(CMD_SHIFT, 0, 0, 0, 60);
    endtask

    task automatic send_random();
        int k, off;
        k = $urandom_range(99);
        if ($urandom_range(3) == 0) off = $signed(23'($urandom));
        else off = $urandom_range(2000) - 1000;
        if (k < 35) begin
            if (k < 5) send_command(CMD_LOAD, $urandom_range(15), $urandom_range(31),
                                    $urandom_range(16383), off);
            else send_command(CMD_LOAD, $urandom_range(12, 1), $urandom_range(31, 1),
                              $urandom_range(MAX_YEAR_DEF, 1), off);
        end else if (k < 70) begin
            send_command(CMD_SHIFT, $urandom_range(15), $urandom_range(31),
                         $urandom_range(16383), off);
        end else if (k < 95) begin
            send_command(CMD_CMP, $urandom_range(15), $urandom_range(31),
                         $urandom_range(16383), off);
        end else begin
            send_command(CMD_NONE, $urandom_range(15), $urandom_range(31),
                         $urandom_range(16383), off);
        end
    endtask

    task automatic test_random(int count);
        repeat (count) send_random();
    endtask

    task automatic test_no_idle(int count);
        src_no_idle = 1; snk_no_idle = 1;
        repeat (count) send_random();
        src_no_idle = 0; snk_no_idle = 0;
    endtask

    // Hold the sink off for a long stretch while commands keep coming
    task automatic test_backpressure();
        fork
            begin
                snk_hold = 1;
                repeat (1500) @(posedge i_clk);
                snk_hold = 0;
            end
            repeat (8) send_random();
        join
        drain_results();
    endtask

    initial begin
        fail_count = 0;
        idle_cycles = 0;
        src_no_idle = 0; snk_no_idle = 0; snk_hold = 0;
        mdl_month = int'(DEF_MONTH); mdl_day = int'(DEF_DAY); mdl_year = int'(DEF_YEAR);
        i_rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.command = CMD_LOAD;
        cmd_ch.in_month = '0;
        cmd_ch.in_day = '0;
        cmd_ch.in_year = '0;
        cmd_ch.day_offset = '0;
        res_ch.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(500);
        drain_results();
        test_no_idle(200);
        test_backpressure();
        test_random(380);

        drain_results();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
